/* sv/ftp_pkg.sv */
// package for the framed telemetry parser: constants, control word type and microcode rom
// no dependencies; used by framed_telemetry_parser and its testbench
`timescale 1ns / 1ps

package ftp_pkg;

    localparam int BUFFER_DEPTH_DEF    = 30;
    localparam int FRACTION_DIGITS_DEF = 3;

    localparam logic [7:0] START_BYTE_RST = 8'd58;  // ':'
    localparam logic [7:0] END_BYTE_RST   = 8'd59;  // ';'

    localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
    localparam logic [7:0] CH_R     = 8'h72;  // 'r'
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'
    localparam logic [7:0] CH_S     = 8'h73;  // 's'
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // config register indexes
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    // accumulator: magnitude limit and width of the times-ten result
    localparam int          ACC_W     = 31;
    localparam int          MUL_W     = 35;
    localparam logic [30:0] MAG_LIMIT = 31'h7FFF_FFFF;

    localparam int STEP_W = 4;

    // read address select
    localparam logic [1:0] A_IDX  = 2'd0;
    localparam logic [1:0] A_TAG1 = 2'd1;
    localparam logic [1:0] A_TAG2 = 2'd2;

    // latch done at every step, whatever the jump does
    localparam logic [1:0] LAT_NONE = 2'd0;
    localparam logic [1:0] LAT_SIDE = 2'd1;
    localparam logic [1:0] LAT_KIND = 2'd2;  // also clears the parse registers

    // jump conditions
    localparam logic [2:0] C_ALWAYS   = 3'd0;
    localparam logic [2:0] C_BAD_SIDE = 3'd1;
    localparam logic [2:0] C_BAD_KIND = 3'd2;
    localparam logic [2:0] C_WS       = 3'd3;
    localparam logic [2:0] C_SIGN     = 3'd4;
    localparam logic [2:0] C_DIGIT    = 3'd5;
    localparam logic [2:0] C_DOT      = 3'd6;
    localparam logic [2:0] C_FD_SHORT = 3'd7;
    localparam logic [2:0] C_OUT_FREE = 3'd7;  // shares the code, told apart by act

    // actions done only when the jump is taken
    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_SKIP = 3'd1;
    localparam logic [2:0] ACT_SIGN = 3'd2;
    localparam logic [2:0] ACT_INT  = 3'd3;
    localparam logic [2:0] ACT_FRAC = 3'd4;
    localparam logic [2:0] ACT_PAD  = 3'd5;
    localparam logic [2:0] ACT_EMIT = 3'd6;

    localparam logic [STEP_W-1:0] STEP_TAG0 = 4'd0;
    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd15;

    typedef struct packed {
        logic [1:0]        asel;
        logic [1:0]        lat;
        logic [2:0]        cond;
        logic [2:0]        act;
        logic [STEP_W-1:0] target;
    } ucw_t;

    function automatic ucw_t uword(logic [1:0] asel, logic [1:0] lat, logic [2:0] cond,
                                   logic [2:0] act, logic [STEP_W-1:0] target);
        ucw_t w;
        w.asel   = asel;
        w.lat    = lat;
        w.cond   = cond;
        w.act    = act;
        w.target = target;
        return w;
    endfunction

    // decode program, entered at step 0 after an end byte
    function automatic ucw_t ucode(logic [STEP_W-1:0] step);
        ucw_t w;
        unique case (step)
            4'd0:    w = uword(A_TAG1, LAT_NONE, C_ALWAYS,   ACT_NONE, 4'd1);
            4'd1:    w = uword(A_TAG2, LAT_SIDE, C_BAD_SIDE, ACT_NONE, STEP_IDLE);
            4'd2:    w = uword(A_IDX,  LAT_KIND, C_BAD_KIND, ACT_NONE, STEP_IDLE);
            4'd3:    w = uword(A_IDX,  LAT_NONE, C_WS,       ACT_SKIP, 4'd3);
            4'd4:    w = uword(A_IDX,  LAT_NONE, C_SIGN,     ACT_SIGN, 4'd5);
            4'd5:    w = uword(A_IDX,  LAT_NONE, C_DIGIT,    ACT_INT,  4'd5);
            4'd6:    w = uword(A_IDX,  LAT_NONE, C_DOT,      ACT_SKIP, 4'd7);
            4'd7:    w = uword(A_IDX,  LAT_NONE, C_DIGIT,    ACT_FRAC, 4'd7);
            4'd8:    w = uword(A_IDX,  LAT_NONE, C_FD_SHORT, ACT_PAD,  4'd8);
            4'd9:    w = uword(A_IDX,  LAT_NONE, C_OUT_FREE, ACT_EMIT, STEP_IDLE);
            4'd10:   w = uword(A_IDX,  LAT_NONE, C_ALWAYS,   ACT_NONE, 4'd9);
            default: w = uword(A_IDX,  LAT_NONE, C_ALWAYS,   ACT_NONE, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

/* sv/ftp_ram.sv */
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ftp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 30
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/framed_telemetry_parser.sv */
// framed telemetry parser top level: byte collection, microcoded decode sequencer, output register
// depends on ftp_pkg and ftp_ram
//
// usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one received character per transfer.
//   the start byte rewinds the write position; the end byte closes the message and starts
//   a decode. messages whose last two characters are d|s then l|r give one result on the
//   out channel (out_valid/out_ready): quantity, milli_value and report_ready.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready and writes start byte
//   (index 0), end byte (index 1); user must write only while the block is idle, not enforced.
// timing:
//   ordinary bytes are taken one per cycle while the sequencer is idle.
//   an end byte runs the decode program on the one buffer read port, one character per
//   cycle, while rx_ready stays low: the tag checks, then blanks, sign, digits, dot, fraction
//   digits and padding in that order; a busy output register adds its wait. a tag that fails
//   sends the sequencer straight back to idle.
// reset: start byte ':' and end byte ';', write position 0, sequencer idle, no result.
// stall: the result sits in the output register; bytes keep being taken, and a following
//   decode waits at its last step until the register frees.
`timescale 1ns / 1ps

module framed_telemetry_parser #(
    parameter int BUFFER_DEPTH    = ftp_pkg::BUFFER_DEPTH_DEF,
    parameter int FRACTION_DIGITS = ftp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  quantity,
    output logic [31:0] milli_value,
    output logic        report_ready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    import ftp_pkg::*;

    localparam int PW  = $clog2(BUFFER_DEPTH);
    localparam int FDW = $clog2(FRACTION_DIGITS + 2);
    localparam logic [PW-1:0] LAST_POS = PW'(BUFFER_DEPTH - 1);

    logic [7:0]        start_reg, end_reg;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     end_pos_reg;
    logic [STEP_W-1:0] upc_reg, upc_next;
    logic [PW-1:0]     idx_reg, idx_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              ovf_reg, ovf_next;
    logic              neg_reg, neg_next;
    logic [FDW-1:0]    fd_reg, fd_next;
    logic              side_reg, kind_reg;

    logic              out_valid_reg;
    logic [1:0]        quantity_reg;
    logic [31:0]       milli_reg;

    ucw_t              cw;
    logic              rx_xfer, is_start, is_end, start_decode, taken;
    logic [7:0]        ch, wdata;
    logic [7:0]        ram_rdata;
    logic [PW-1:0]     raddr;
    logic              c_ws, c_sign, c_digit, c_dot, fd_short, out_free;
    logic [3:0]        mac_digit;
    logic [MUL_W-1:0]  mac;
    logic              do_mac, emit;
    logic [ACC_W-1:0]  mag;

    assign cfg_ready = 1'b1;
    assign rx_ready  = (upc_reg == STEP_IDLE);
    assign rx_xfer   = rx_valid && rx_ready;

    assign is_start     = (rx_byte == start_reg);
    assign is_end       = (rx_byte == end_reg) && !is_start;
    assign start_decode = rx_xfer && is_end && (pos_reg >= PW'(2));
    assign wdata        = is_end ? 8'h00 : rx_byte;

    always_comb
    begin
        if (is_start)
        begin
            pos_next = '0;
        end
        else if (pos_reg == LAST_POS)
        begin
            pos_next = LAST_POS;
        end
        else
        begin
            pos_next = pos_reg + PW'(1);
        end
    end

    // --- sequencer ---
    assign cw = ucode(upc_reg);
    assign ch = ram_rdata;

    assign c_ws     = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign c_sign   = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign c_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign c_dot    = (ch == CH_DOT);
    assign fd_short = (32'(fd_reg) < FRACTION_DIGITS);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (cw.cond)
            C_ALWAYS:   taken = 1'b1;
            C_BAD_SIDE: taken = (ch != CH_L) && (ch != CH_R);
            C_BAD_KIND: taken = (ch != CH_D) && (ch != CH_S);
            C_WS:       taken = c_ws;
            C_SIGN:     taken = c_sign;
            C_DIGIT:    taken = c_digit;
            C_DOT:      taken = c_dot;
            // pad and emit share this code
            C_FD_SHORT: taken = (cw.act == ACT_EMIT) ? out_free : fd_short;
            default:    taken = 1'b0;
        endcase
    end

    assign emit = taken && (cw.act == ACT_EMIT);

    always_comb
    begin
        if (start_decode)
        begin
            upc_next = STEP_TAG0;
        end
        else if (upc_reg == STEP_IDLE)
        begin
            upc_next = STEP_IDLE;
        end
        else if (taken)
        begin
            upc_next = cw.target;
        end
        else
        begin
            upc_next = upc_reg + STEP_W'(1);
        end
    end

    // --- parse datapath ---
    // one shared times-ten-plus-digit unit with sticky saturation
    assign mac_digit = (cw.act == ACT_PAD) ? 4'd0 : ch[3:0];
    assign mac = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + MUL_W'(mac_digit);

    always_comb
    begin
        idx_next = idx_reg;
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        neg_next = neg_reg;
        fd_next  = fd_reg;
        do_mac   = 1'b0;
        if (cw.lat == LAT_KIND)
        begin
            idx_next = '0;
            acc_next = '0;
            ovf_next = 1'b0;
            neg_next = 1'b0;
            fd_next  = '0;
        end
        else if (taken)
        begin
            case (cw.act)
                ACT_SKIP:
                begin
                    idx_next = idx_reg + PW'(1);
                end
                ACT_SIGN:
                begin
                    idx_next = idx_reg + PW'(1);
                    neg_next = (ch == CH_MINUS);
                end
                ACT_INT:
                begin
                    idx_next = idx_reg + PW'(1);
                    do_mac   = 1'b1;
                end
                ACT_FRAC:
                begin
                    idx_next = idx_reg + PW'(1);
                    if (fd_short)
                    begin
                        do_mac  = 1'b1;
                        fd_next = fd_reg + FDW'(1);
                    end
                end
                ACT_PAD:
                begin
                    do_mac  = 1'b1;
                    fd_next = fd_reg + FDW'(1);
                end
                default:
                begin
                end
            endcase
        end
        if (do_mac)
        begin
            acc_next = mac[ACC_W-1:0];
            if (mac > MUL_W'(MAG_LIMIT))
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (cw.asel)
            A_TAG1:  raddr = end_pos_reg - PW'(1);
            A_TAG2:  raddr = end_pos_reg - PW'(2);
            default: raddr = idx_next;
        endcase
    end

    assign mag = ovf_reg ? MAG_LIMIT : acc_reg;

    ftp_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_text_ram (
        .clk   (clk),
        .we    (rx_xfer),
        .waddr (pos_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // --- registers ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= START_BYTE_RST;
            end_reg       <= END_BYTE_RST;
            pos_reg       <= '0;
            upc_reg       <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START)
                begin
                    start_reg <= cfg_data;
                end
                else
                begin
                    end_reg <= cfg_data;
                end
            end
            if (rx_xfer)
            begin
                pos_reg <= pos_next;
            end
            upc_reg <= upc_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_decode)
        begin
            end_pos_reg <= pos_reg;
        end
        if (cw.lat == LAT_SIDE)
        begin
            side_reg <= (ch == CH_R);
        end
        if (cw.lat == LAT_KIND)
        begin
            kind_reg <= (ch == CH_S);
        end
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
        fd_reg  <= fd_next;
        if (emit)
        begin
            quantity_reg <= {side_reg, kind_reg};
            milli_reg    <= neg_reg ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
        end
    end

    assign out_valid    = out_valid_reg;
    assign quantity     = quantity_reg;
    assign milli_value  = milli_reg;
    assign report_ready = (quantity_reg == 2'd3);

    // --- assertions ---
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("write position past last slot");

    a_decode_entry: assert property (@(posedge clk) disable iff (!rst_n)
        start_decode |=> (upc_reg == STEP_TAG0) && !rx_ready)
        else $error("end byte did not start decode");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg != STEP_IDLE) && (upc_reg > 4'd2) |-> idx_reg <= end_pos_reg)
        else $error("parse scan ran past terminator");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_valid_reg || out_ready)
        else $error("result overwrote a pending transfer");

endmodule

/* sim/tb_framed_telemetry_parser.sv */
// testbench for framed_telemetry_parser: byte frames in, decoded telemetry readings out,
// checked against a scoreboard that tracks the text buffer itself
// depends on ftp_pkg and the framed_telemetry_parser rtl
`timescale 1ns / 1ps

module tb_framed_telemetry_parser;
    import ftp_pkg::*;

    localparam int          HALF_PERIOD  = 4;
    localparam int          DEPTH        = BUFFER_DEPTH_DEF;
    localparam int          FRAC_DIGITS  = FRACTION_DIGITS_DEF;
    localparam int          IDLE_SETTLE  = 2 * (DEPTH + FRAC_DIGITS + 10);
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          REPORT_LIMIT = 10;
    localparam logic [7:0]  TERMINATOR   = 8'h00;
    localparam logic [63:0] WHOLE_CAP    = 64'd10000000000;
    localparam logic [63:0] MILLI_CAP    = 64'd2147483647;

    localparam logic [1:0] Q_LEFT_DISP  = 2'd0;
    localparam logic [1:0] Q_LEFT_SPEED = 2'd1;
    localparam logic [1:0] Q_RIGHT_DISP = 2'd2;
    localparam logic [1:0] Q_RIGHT_SPEED = 2'd3;

    typedef struct packed {
        logic [1:0]  quantity;
        logic [31:0] milli_value;
        logic        report_ready;
    } telemetry_t;

    class telemetry_scoreboard;
        logic [7:0]  text_buf [DEPTH];
        int unsigned wr_pos;
        logic [7:0]  start_ch;
        logic [7:0]  end_ch;
        telemetry_t  expected_q [$];
        int unsigned mismatches;

        function new();
            foreach (text_buf[i])
                text_buf[i] = 8'h00;
            wr_pos     = 0;
            start_ch   = START_BYTE_RST;
            end_ch     = END_BYTE_RST;
            mismatches = 0;
        endfunction

        function void set_register(logic idx, logic [7:0] data);
            if (idx == CFG_START)
                start_ch = data;
            else
                end_ch = data;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        // leading decimal text from slot 0, scaled by 10^FRAC_DIGITS and saturated
        function logic [31:0] parse_milli(int unsigned limit, output bit neg);
            int unsigned     i;
            int unsigned     fd;
            int unsigned     k;
            logic [63:0]     whole;
            logic [63:0]     frac;
            logic [63:0]     scale;
            logic [63:0]     total;
            i     = 0;
            fd    = 0;
            whole = 0;
            frac  = 0;
            scale = 1;
            neg   = 1'b0;
            while (i < limit && is_blank(text_buf[i]))
                i++;
            if (i < limit && (text_buf[i] == CH_PLUS || text_buf[i] == CH_MINUS))
            begin
                neg = (text_buf[i] == CH_MINUS);
                i++;
            end
            while (i < limit && is_digit(text_buf[i]))
            begin
                whole = whole * 64'd10 + 64'(text_buf[i] - CH_ZERO);
                if (whole > WHOLE_CAP)
                    whole = WHOLE_CAP;
                i++;
            end
            if (i < limit && text_buf[i] == CH_DOT)
            begin
                i++;
                while (i < limit && is_digit(text_buf[i]))
                begin
                    // digits past the fraction width are dropped
                    if (fd < FRAC_DIGITS)
                    begin
                        frac = frac * 64'd10 + 64'(text_buf[i] - CH_ZERO);
                        fd++;
                    end
                    i++;
                end
            end
            for (k = 0; k < FRAC_DIGITS; k++)
                scale = scale * 64'd10;
            for (; fd < FRAC_DIGITS; fd++)
                frac = frac * 64'd10;
            total = whole * scale + frac;
            if (total > MILLI_CAP)
                total = MILLI_CAP;
            return total[31:0];
        endfunction

        function void decode_frame(int unsigned p);
            logic [7:0]  side;
            logic [7:0]  kind;
            logic [31:0] mag;
            bit          neg;
            telemetry_t  reading;
            if (p < 2)
                return;
            side = text_buf[p - 1];
            kind = text_buf[p - 2];
            if (kind != CH_D && kind != CH_S)
                return;
            if (side == CH_L)
                reading.quantity = (kind == CH_S) ? Q_LEFT_SPEED : Q_LEFT_DISP;
            else if (side == CH_R)
                reading.quantity = (kind == CH_S) ? Q_RIGHT_SPEED : Q_RIGHT_DISP;
            else
                return;
            mag = parse_milli(p + 1, neg);
            reading.milli_value  = neg ? (32'd0 - mag) : mag;
            reading.report_ready = (reading.quantity == Q_RIGHT_SPEED);
            expected_q.push_back(reading);
        endfunction

        function void note_byte(logic [7:0] b);
            int unsigned p;
            int unsigned nxt;
            p = wr_pos;
            if (p >= DEPTH)
                p = DEPTH - 1;
            text_buf[p] = b;
            // start wins when start and end bytes are equal
            if (b == start_ch)
                nxt = 0;
            else
            begin
                if (b == end_ch)
                begin
                    text_buf[p] = TERMINATOR;
                    decode_frame(p);
                end
                nxt = p + 1;
            end
            // a full buffer keeps overwriting its last slot
            if (nxt >= DEPTH)
                nxt = DEPTH - 1;
            wr_pos = nxt;
        endfunction

        function void check_result(telemetry_t got);
            telemetry_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected reading: q=%0d v=%0d r=%0d", got.quantity,
                             $signed(got.milli_value), got.report_ready);
                return;
            end
            want = expected_q.pop_front();
            if (got.quantity != want.quantity || got.milli_value != want.milli_value ||
                got.report_ready != want.report_ready)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("reading mismatch: expected q=%0d v=%0d r=%0d, got q=%0d v=%0d r=%0d",
                             want.quantity, $signed(want.milli_value), want.report_ready,
                             got.quantity, $signed(got.milli_value), got.report_ready);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  quantity;
    logic [31:0] milli_value;
    logic        report_ready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    telemetry_scoreboard telemetry_sb;
    logic [7:0]          frame_bytes [$];
    int unsigned         burst_left;
    int unsigned         bytes_sent;
    int unsigned         cycles;
    int unsigned         stall_mode;
    int unsigned         mode_left;
    int unsigned         hold_left;
    logic                hold_level;
    telemetry_t          seen_reading;

    framed_telemetry_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .quantity     (quantity),
        .milli_value  (milli_value),
        .report_ready (report_ready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
        clk = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL framed_telemetry_parser");
            $finish;
        end
    end

    // receiver: switches between always ready, coin-flip stalls and long stall stretches
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_reading.quantity     = quantity;
            seen_reading.milli_value  = milli_value;
            seen_reading.report_ready = report_ready;
            telemetry_sb.check_result(seen_reading);
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(64, 256);
        end
        mode_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_level = ~hold_level;
                    hold_left  = hold_level ? $urandom_range(1, 4) : $urandom_range(5, 20);
                end
                hold_left--;
                out_ready <= hold_level;
            end
        endcase
    end

    function automatic logic [7:0] rand_byte(int unsigned lo, int unsigned hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] rand_digit();
        return rand_byte(CH_ZERO, CH_NINE);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            if (gap != 0)
            begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        telemetry_sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic drain_results();
        rx_valid <= 1'b0;
        while (telemetry_sb.pending() != 0)
            @(posedge clk);
    endtask

    // a decode with a bad tag gives nothing back, so let it finish before touching registers
    task automatic wait_idle();
        drain_results();
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        telemetry_sb.set_register(idx, data);
    endtask

    task automatic build_frame();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  st;
        logic [7:0]  en;
        st = telemetry_sb.start_ch;
        en = telemetry_sb.end_ch;
        frame_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            // well-formed frame, now and then without the rewind
            if ($urandom_range(0, 9) != 0)
                frame_bytes.push_back(st);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n)
                frame_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : rand_byte(CH_TAB, CH_CR));
            case ($urandom_range(0, 3))
                0: frame_bytes.push_back(CH_PLUS);
                1: frame_bytes.push_back(CH_MINUS);
                default: ;
            endcase
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4);
            repeat (n)
                frame_bytes.push_back(rand_digit());
            if ($urandom_range(0, 2) != 0)
            begin
                frame_bytes.push_back(CH_DOT);
                repeat ($urandom_range(0, 5))
                    frame_bytes.push_back(rand_digit());
            end
            frame_bytes.push_back($urandom_range(0, 1) ? CH_S : CH_D);
            frame_bytes.push_back($urandom_range(0, 1) ? CH_R : CH_L);
            frame_bytes.push_back(en);
        end
        else if (pick < 82)
        begin
            // junk in the body or a damaged tag
            frame_bytes.push_back(st);
            repeat ($urandom_range(0, 4))
                frame_bytes.push_back(rand_digit());
            repeat ($urandom_range(0, 3))
                frame_bytes.push_back(rand_byte(0, 255));
            case ($urandom_range(0, 2))
                0: frame_bytes.push_back(CH_D);
                1: frame_bytes.push_back(CH_S);
                default: frame_bytes.push_back(rand_byte(0, 255));
            endcase
            case ($urandom_range(0, 2))
                0: frame_bytes.push_back(CH_L);
                1: frame_bytes.push_back(CH_R);
                default: frame_bytes.push_back(rand_byte(0, 255));
            endcase
            frame_bytes.push_back(en);
        end
        else if (pick < 90)
        begin
            // overruns the buffer so the last slot gets overwritten
            frame_bytes.push_back(st);
            repeat ($urandom_range(28, 40))
                frame_bytes.push_back($urandom_range(0, 1) ? rand_digit() : rand_byte(0, 255));
            frame_bytes.push_back($urandom_range(0, 1) ? CH_S : CH_D);
            frame_bytes.push_back($urandom_range(0, 1) ? CH_R : CH_L);
            frame_bytes.push_back(en);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                frame_bytes.push_back(rand_byte(0, 255));
        end
    endtask

    task automatic run_phase(input int unsigned n_bytes);
        int unsigned first;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes)
        begin
            build_frame();
            foreach (frame_bytes[k])
                send_byte(frame_bytes[k]);
        end
    endtask

    initial
    begin
        telemetry_sb = new();
        burst_left   = 0;
        bytes_sent   = 0;
        stall_mode   = 0;
        mode_left    = 0;
        hold_left    = 0;
        hold_level   = 1'b0;
        cycles       <= 0;
        rst_n        <= 1'b0;
        rx_valid     <= 1'b0;
        rx_byte      <= 8'h00;
        out_ready    <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_START;
        cfg_data     <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // byte extremes, fraction truncation, no rewind after an end byte,
        // too short a message, whitespace and a bare fraction
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text(":-12.3456dl;");
        send_text("7sr;");
        send_text(":x;");
        send_text(": \t-.5dr;");
        drain_results();

        run_phase(95);

        wait_idle();
        cfg_write(CFG_START, 8'hFF);
        cfg_write(CFG_END, 8'h00);
        cfg_valid <= 1'b0;
        run_phase(95);

        wait_idle();
        cfg_write(CFG_START, 8'h00);
        cfg_write(CFG_END, 8'hFF);
        cfg_valid <= 1'b0;
        run_phase(95);

        // start and end share one byte: nothing is ever closed
        wait_idle();
        cfg_write(CFG_START, 8'h23);
        cfg_write(CFG_END, 8'h23);
        cfg_valid <= 1'b0;
        run_phase(55);

        wait_idle();
        cfg_write(CFG_START, 8'h3C);
        cfg_write(CFG_END, 8'h3E);
        cfg_valid <= 1'b0;
        run_phase(95);

        wait_idle();
        cfg_write(CFG_END, END_BYTE_RST);
        cfg_write(CFG_START, START_BYTE_RST);
        cfg_valid <= 1'b0;
        run_phase(85);

        wait_idle();
        if (telemetry_sb.mismatches == 0 && telemetry_sb.pending() == 0)
            $display("PASS framed_telemetry_parser");
        else
            $display("FAIL framed_telemetry_parser");
        $finish;
    end

endmodule
